/* sv/mer_pkg.sv */
// Shared types and constants for the midpoint ellipse rasterizer.
package mer_pkg;

    localparam int CENTRE_BITS = 11;
    localparam int PIX_BITS    = 13;
    localparam int PIX_COUNT   = 8;
    localparam int OUT_DATA_W  = PIX_BITS * PIX_COUNT;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SQUARE  = 4'b0010,
        ST_PRODUCT = 4'b0100,
        ST_EMIT    = 4'b1000
    } eng_state_t;

    // Status of the queue head as the engine sees it.
    typedef struct packed {
        logic valid;
        logic is_start;
    } head_t;

endpackage

/* sv/midpoint_ellipse_rasterizer_core.sv */
// Midpoint ellipse rasterizer: a two-entry input queue in front of the stepping engine.
// Throughput: one step beat per cycle while the engine is idle and the output is not stalled; a start
// holds the engine while it captures the start, squares the radii, forms the radius product and emits
// the first point.
// The output register frees the input side while a finished beat waits for m_axis_tready.
// Reset (rst_n low, asynchronous) empties the queue and output and leaves no ellipse running.
module midpoint_ellipse_rasterizer_core #(
    parameter int RADIUS_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // radius_x, radius_y, centre_x, centre_y, zero padding
    input  logic [((2*RADIUS_BITS+2*mer_pkg::CENTRE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pix0_x, pix0_y, pix1_x, pix1_y, pix2_x, pix2_y, pix3_x, pix3_y
    output logic [mer_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // last_point
    output logic                           m_axis_tlast,
    // no_point
    output logic                           m_axis_tuser
);
    localparam int FIELD_W = 2*RADIUS_BITS + 2*mer_pkg::CENTRE_BITS;

    mer_pkg::head_t                  head;
    logic                            pop;
    logic [RADIUS_BITS-1:0]          head_radius_x, head_radius_y;
    logic [mer_pkg::CENTRE_BITS-1:0] head_centre_x, head_centre_y;

    mer_front #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_fields (s_axis_tdata[FIELD_W-1:0]),
        .s_axis_tuser  (s_axis_tuser),
        .pop           (pop),
        .head          (head),
        .head_radius_x (head_radius_x),
        .head_radius_y (head_radius_y),
        .head_centre_x (head_centre_x),
        .head_centre_y (head_centre_y)
    );

    mer_engine #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_radius_x (head_radius_x),
        .head_radius_y (head_radius_y),
        .head_centre_x (head_centre_x),
        .head_centre_y (head_centre_y),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* sv/mer_front.sv */
// Input side: accepts beats into a two-entry queue and classifies the head item.
module mer_front #(
    parameter int RADIUS_BITS = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [2*RADIUS_BITS+2*mer_pkg::CENTRE_BITS-1:0] s_axis_fields,
    input  logic                            s_axis_tuser,
    input  logic                            pop,
    output mer_pkg::head_t                  head,
    output logic [RADIUS_BITS-1:0]          head_radius_x,
    output logic [RADIUS_BITS-1:0]          head_radius_y,
    output logic [mer_pkg::CENTRE_BITS-1:0] head_centre_x,
    output logic [mer_pkg::CENTRE_BITS-1:0] head_centre_y
);
    localparam int CB      = mer_pkg::CENTRE_BITS;
    localparam int FIELD_W = 2*RADIUS_BITS + 2*CB;
    localparam int ENTRY_W = FIELD_W + 1;

    logic [ENTRY_W-1:0] slot_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               push;
    logic [ENTRY_W-1:0] head_entry;

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign head_entry    = slot_reg[rd_ptr_reg];

    assign head.valid    = (count_reg != 2'd0);
    assign head.is_start = (head_entry[FIELD_W] == mer_pkg::MODE_START);
    assign head_radius_x = head_entry[RADIUS_BITS-1:0];
    assign head_radius_y = head_entry[2*RADIUS_BITS-1:RADIUS_BITS];
    assign head_centre_x = head_entry[2*RADIUS_BITS+CB-1:2*RADIUS_BITS];
    assign head_centre_y = head_entry[FIELD_W-1:2*RADIUS_BITS+CB];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= {s_axis_tuser, s_axis_fields};
        end
    end

endmodule

/* sv/mer_engine.sv */
// Back end: sets up an ellipse, steps the midpoint recurrence and holds the output beat.
module mer_engine #(
    parameter int RADIUS_BITS = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mer_pkg::head_t                  head,
    input  logic [RADIUS_BITS-1:0]          head_radius_x,
    input  logic [RADIUS_BITS-1:0]          head_radius_y,
    input  logic [mer_pkg::CENTRE_BITS-1:0] head_centre_x,
    input  logic [mer_pkg::CENTRE_BITS-1:0] head_centre_y,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mer_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tuser
);
    localparam int R    = RADIUS_BITS;
    localparam int CB   = mer_pkg::CENTRE_BITS;
    localparam int PW   = mer_pkg::PIX_BITS;
    localparam int SQ_W = 2*R;
    localparam int PR_W = 3*R;
    localparam int X_W  = R + 2;
    localparam int Y_W  = R + 2;
    localparam int G_W  = 3*R + 4;
    localparam int P_W  = 4*R + 4;

    mer_pkg::eng_state_t state_reg, state_next;

    logic [R-1:0]                rx_reg, ry_reg;
    logic [CB-1:0]               cx_reg, cy_reg;
    logic [SQ_W-1:0]             rx2_reg, ry2_reg;
    logic [X_W-1:0]              x_reg;
    logic signed [Y_W-1:0]       y_reg;
    logic signed [G_W-1:0]       fx_reg, fy_reg;
    logic signed [P_W-1:0]       p_reg;
    logic                        region2_reg;
    logic                        active_reg;

    logic                        out_valid_reg;
    logic [mer_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic                        out_last_reg;
    logic                        out_none_reg;

    logic                        out_free;
    logic                        emit;
    logic                        take_start;

    logic [PR_W-1:0]             prod;
    logic signed [G_W-1:0]       two_rx2, two_ry2;
    logic signed [P_W-1:0]       rx2_ext, ry2_ext;

    logic                        grow_x, fall_y;
    logic [X_W-1:0]              x_n;
    logic signed [Y_W-1:0]       y_n;
    logic signed [G_W-1:0]       fx_n, fy_n;
    logic signed [P_W-1:0]       p_n;
    logic                        region2_n;
    logic                        active_n;

    logic [PW-1:0]               cxp, cyp, xp, yp;
    logic [mer_pkg::OUT_DATA_W-1:0] pix_data;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        take_start = 1'b0;
        unique case (state_reg)
            mer_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.is_start)
                    begin
                        pop        = 1'b1;
                        take_start = 1'b1;
                        state_next = mer_pkg::ST_SQUARE;
                    end
                    else if (out_free)
                    begin
                        pop  = 1'b1;
                        emit = 1'b1;
                    end
                end
            end
            mer_pkg::ST_SQUARE:  state_next = mer_pkg::ST_PRODUCT;
            mer_pkg::ST_PRODUCT: state_next = mer_pkg::ST_EMIT;
            mer_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = mer_pkg::ST_IDLE;
                end
            end
            default: state_next = mer_pkg::ST_IDLE;
        endcase
    end

    // Gradient steps are twice the squares; fx and fy move by these whenever y or x moves.
    assign two_rx2 = {{(G_W-SQ_W-1){1'b0}}, rx2_reg, 1'b0};
    assign two_ry2 = {{(G_W-SQ_W-1){1'b0}}, ry2_reg, 1'b0};
    assign rx2_ext = {{(P_W-SQ_W){1'b0}}, rx2_reg};
    assign ry2_ext = {{(P_W-SQ_W){1'b0}}, ry2_reg};
    assign prod    = PR_W'(rx2_reg) * PR_W'(ry_reg);

    always_comb
    begin
        grow_x    = !region2_reg || (p_reg <= 0);
        fall_y    = region2_reg || (p_reg >= 0);
        x_n       = grow_x ? x_reg + X_W'(1) : x_reg;
        fy_n      = grow_x ? fy_reg + two_ry2 : fy_reg;
        y_n       = fall_y ? y_reg - Y_W'(1) : y_reg;
        fx_n      = fall_y ? fx_reg - two_rx2 : fx_reg;
        p_n       = p_reg
                  + (grow_x ? P_W'(fy_n) : P_W'(0))
                  - (fall_y ? P_W'(fx_n) : P_W'(0))
                  + (region2_reg ? rx2_ext : ry2_ext);
        region2_n = region2_reg || !(fx_n > fy_n);
        active_n  = !(region2_n && y_n[Y_W-1]);
    end

    always_comb
    begin
        cxp      = PW'(cx_reg);
        cyp      = PW'(cy_reg);
        xp       = PW'(x_reg);
        yp       = PW'(y_reg);
        pix_data = {cyp - yp, cxp + xp,
                    cyp - yp, cxp - xp,
                    cyp + yp, cxp - xp,
                    cyp + yp, cxp + xp};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mer_pkg::ST_IDLE;
            active_reg    <= 1'b0;
            region2_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mer_pkg::ST_PRODUCT)
            begin
                active_reg  <= 1'b1;
                region2_reg <= (prod == '0);
            end
            else if (emit && active_reg)
            begin
                active_reg  <= active_n;
                region2_reg <= region2_n;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_start)
        begin
            rx_reg <= head_radius_x;
            ry_reg <= head_radius_y;
            cx_reg <= head_centre_x;
            cy_reg <= head_centre_y;
        end
        if (state_reg == mer_pkg::ST_SQUARE)
        begin
            rx2_reg <= SQ_W'(rx_reg) * SQ_W'(rx_reg);
            ry2_reg <= SQ_W'(ry_reg) * SQ_W'(ry_reg);
        end
        if (state_reg == mer_pkg::ST_PRODUCT)
        begin
            x_reg  <= '0;
            y_reg  <= {2'b00, ry_reg};
            fy_reg <= '0;
            fx_reg <= {{(G_W-PR_W-1){1'b0}}, prod, 1'b0};
            p_reg  <= ry2_ext - {{(P_W-PR_W){1'b0}}, prod}
                    + {{(P_W-SQ_W+2){1'b0}}, rx2_reg[SQ_W-1:2]};
        end
        else if (emit && active_reg)
        begin
            x_reg  <= x_n;
            y_reg  <= y_n;
            fx_reg <= fx_n;
            fy_reg <= fy_n;
            p_reg  <= p_n;
        end
        if (emit)
        begin
            out_data_reg <= active_reg ? pix_data : '0;
            out_last_reg <= active_reg && !active_n;
            out_none_reg <= !active_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_none_reg;

endmodule

/* sv/mer_checker.sv */
// Port-level checks on the rasterizer output stream, bound to the top level.
module mer_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mer_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast,
    input logic                           m_axis_tuser
);
    localparam int PW = mer_pkg::PIX_BITS;

    // A stalled beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat withdrawn while stalled");

    // A stalled beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // A step with no ellipse running carries no pixels and never ends an ellipse.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
        else $error("no-point beat carries data or end flag");

    // The final point of an ellipse lies on the horizontal axis, so both rows coincide.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[2*PW-1:PW] == m_axis_tdata[6*PW-1:5*PW])
        else $error("last point is off the horizontal axis");

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker u_mer_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/midpoint_ellipse_rasterizer_core_tb.sv */
// Self-checking testbench for the midpoint ellipse rasterizer core.
module midpoint_ellipse_rasterizer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RADIUS_BITS = 10;
    localparam int IN_DATA_W   = ((2*RADIUS_BITS + 2*mer_pkg::CENTRE_BITS + 7)/8)*8;
    localparam int RANDOM_BEATS = 1400;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [mer_pkg::OUT_DATA_W-1:0] pixels;
        logic                           last_point;
        logic                           no_point;
    } point_beat_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [IN_DATA_W-1:0]           s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [mer_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tlast;
    logic                           m_axis_tuser;

    // Tracer state; all but the x offset and the gradients are kept at the widths the block holds them in.
    bit        [10:0] x_off;
    bit signed [11:0] y_off;
    bit signed [43:0] decision;
    bit signed [32:0] grad_x;
    bit signed [32:0] grad_y;
    bit        [19:0] rx_sq;
    bit        [19:0] ry_sq;
    bit               in_region_two;
    bit               tracing;
    bit        [10:0] held_cx;
    bit        [10:0] held_cy;

    point_beat_t pending_points[$];
    int          mismatches = 0;
    int          sent_beats = 0;
    bit          no_idle = 1'b0;
    int          ready_stall = 0;

    midpoint_ellipse_rasterizer_core #(
        .RADIUS_BITS(RADIUS_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly no gap, sometimes a short one and now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Emits the current point as four mirrored pixels, then moves one step along the quadrant.
    function automatic point_beat_t trace_next_point();
        point_beat_t b;
        longint cx, cy, x, y, p, fx, fy, rxs, rys;
        cx = held_cx;
        cy = held_cy;
        x = x_off;
        y = y_off;
        p = decision;
        fx = grad_x;
        fy = grad_y;
        rxs = rx_sq;
        rys = ry_sq;
        b.pixels[12:0]   = 13'(cx + x);
        b.pixels[25:13]  = 13'(cy + y);
        b.pixels[38:26]  = 13'(cx - x);
        b.pixels[51:39]  = 13'(cy + y);
        b.pixels[64:52]  = 13'(cx - x);
        b.pixels[77:65]  = 13'(cy - y);
        b.pixels[90:78]  = 13'(cx + x);
        b.pixels[103:91] = 13'(cy - y);
        if (!in_region_two)
        begin
            x = x + 1;
            fy = 2 * rys * x;
            if (p >= 0)
            begin
                y = y - 1;
                fx = 2 * rxs * y;
                p = p + fy - fx + rys;
            end
            else
                p = p + fy + rys;
            if (!(fx > fy))
                in_region_two = 1'b1;
        end
        else
        begin
            y = y - 1;
            fx = 2 * rxs * y;
            if (p <= 0)
            begin
                x = x + 1;
                fy = 2 * rys * x;
                p = p + fy - fx + rxs;
            end
            else
                p = p - fx + rxs;
        end
        if (in_region_two && y < 0)
            tracing = 1'b0;
        x_off = 11'(x);
        y_off = 12'(y);
        decision = 44'(p);
        grad_x = 33'(fx);
        grad_y = 33'(fy);
        b.last_point = !tracing;
        b.no_point = 1'b0;
        return b;
    endfunction

    function automatic point_beat_t predict_beat(bit mode, bit [9:0] rx, bit [9:0] ry,
                                                  bit [10:0] cx, bit [10:0] cy);
        point_beat_t b;
        longint rxl, ryl, rxs, rys;
        if (mode == mer_pkg::MODE_START)
        begin
            rxl = rx;
            ryl = ry;
            rxs = rxl * rxl;
            rys = ryl * ryl;
            held_cx = cx;
            held_cy = cy;
            rx_sq = 20'(rxs);
            ry_sq = 20'(rys);
            x_off = '0;
            y_off = 12'(ryl);
            decision = 44'(rys - rxs * ryl + rxs / 4);
            grad_x = 33'(2 * rxs * ryl);
            grad_y = '0;
            in_region_two = !(2 * rxs * ryl > 0);
            tracing = 1'b1;
            return trace_next_point();
        end
        if (tracing)
            return trace_next_point();
        b = '0;
        b.no_point = 1'b1;
        return b;
    endfunction

    task automatic send_item(bit mode, bit [9:0] rx, bit [9:0] ry, bit [10:0] cx, bit [10:0] cy);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(IN_DATA_W-42){1'b0}}, cy, cx, ry, rx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_points.push_back(predict_beat(mode, rx, ry, cx, cy));
        sent_beats++;
    endtask

    task automatic send_step();
        send_item(mer_pkg::MODE_STEP, 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                  11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
    endtask

    // Starts an ellipse and steps it until it ends or the step budget runs out, then sends the idle steps.
    task automatic trace_ellipse(bit [9:0] rx, bit [9:0] ry, bit [10:0] cx, bit [10:0] cy,
                                 int max_steps, int idle_steps);
        int steps;
        steps = 0;
        send_item(mer_pkg::MODE_START, rx, ry, cx, cy);
        while (tracing && steps < max_steps)
        begin
            send_step();
            steps++;
        end
        repeat (idle_steps) send_step();
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    function automatic bit [9:0] pick_radius();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 10'($urandom_range(0, 12));
        else if (r < 93)
            return 10'($urandom_range(13, 40));
        else
            return 10'($urandom_range(0, 1023));
    endfunction

    task automatic test_idle_steps();
        no_idle = 1'b1;
        repeat (3) send_step();
        no_idle = 1'b0;
    endtask

    task automatic test_degenerate_and_extremes();
        trace_ellipse(10'd0, 10'd0, 11'd0, 11'd0, 10, 1);
        trace_ellipse(10'd0, 10'd3, 11'd2047, 11'd2047, 10, 0);
        trace_ellipse(10'd4, 10'd0, 11'd0, 11'd2047, 10, 0);
        // A fresh start while the large ellipse is still running drops it.
        trace_ellipse(10'd1023, 10'd1023, 11'd2047, 11'd0, 2, 0);
        trace_ellipse(10'd1023, 10'd1, 11'd1024, 11'd1023, 2, 0);
        trace_ellipse(10'd2, 10'd1, 11'd5, 11'd1, 20, 1);
    endtask

    task automatic test_sender_pause();
        trace_ellipse(10'd20, 10'd12, 11'd700, 11'd300, 10, 0);
        wait_for_drain();
        while (tracing)
            send_step();
        send_step();
    endtask

    task automatic test_random_ellipses();
        int r;
        int next_drain;
        bit [9:0] rx, ry;
        next_drain = sent_beats + 250;
        while (sent_beats < RANDOM_BEATS)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 15)
                no_idle = !no_idle;
            if (r < 5)
                send_step();
            else
            begin
                rx = pick_radius();
                ry = pick_radius();
                if (rx > 40 || ry > 40 || r < 15)
                    trace_ellipse(rx, ry, 11'($urandom_range(0, 2047)),
                                  11'($urandom_range(0, 2047)), $urandom_range(0, 30), 0);
                else
                    trace_ellipse(rx, ry, 11'($urandom_range(0, 2047)),
                                  11'($urandom_range(0, 2047)), 100000, $urandom_range(0, 2));
            end
            if (sent_beats >= next_drain)
            begin
                wait_for_drain();
                next_drain = sent_beats + 250;
            end
        end
        no_idle = 1'b0;
    endtask

    // Result checker and receiver back-pressure.
    always @(posedge clk)
    begin
        point_beat_t                   want;
        logic [mer_pkg::PIX_BITS-1:0] got_pix;
        logic [mer_pkg::PIX_BITS-1:0] want_pix;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_points.size() == 0)
            begin
                $error("unexpected result beat: tdata=%h tlast=%b tuser=%b",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_points.pop_front();
                for (int k = 0; k < mer_pkg::PIX_COUNT; k++)
                begin
                    got_pix  = m_axis_tdata[k*mer_pkg::PIX_BITS +: mer_pkg::PIX_BITS];
                    want_pix = want.pixels[k*mer_pkg::PIX_BITS +: mer_pkg::PIX_BITS];
                    if (got_pix != want_pix)
                    begin
                        $error("pix%0d_%s: expected %0d, got %0d", k / 2, (k % 2) ? "y" : "x",
                               $signed(want_pix), $signed(got_pix));
                        mismatches++;
                    end
                end
                if (m_axis_tlast != want.last_point)
                begin
                    $error("last_point: expected %0b, got %0b", want.last_point, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tuser != want.no_point)
                begin
                    $error("no_point: expected %0b, got %0b", want.no_point, m_axis_tuser);
                    mismatches++;
                end
            end
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (ready_stall > 0)
        begin
            ready_stall--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            ready_stall = pick_gap();
            if (ready_stall > 0)
            begin
                ready_stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Ends the run when no beat moves on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_steps();
        test_degenerate_and_extremes();
        test_sender_pause();
        test_random_ellipses();
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
sv/mer_pkg.sv
sv/mer_front.sv
sv/mer_engine.sv
sv/midpoint_ellipse_rasterizer_core.sv
sv/mer_checker.sv
tb/sv/midpoint_ellipse_rasterizer_core_tb.sv
